// ----- sv/ebrae_pkg.sv -----
// Package for the eight-bit register ALU execute block.
// Holds operation codes, register indexes, payload structs and the divide step.
// No dependencies.
`timescale 1ns / 1ps

package ebrae_pkg;

   localparam int NUM_REGS_DEFAULT   = 13;
   localparam int QUEUE_DEPTH        = 2;
   localparam int DIV_BITS_PER_CYCLE = 2;
   localparam int DIV_CYCLES         = 8 / DIV_BITS_PER_CYCLE;

   localparam logic [3:0] REG_ZERO   = 4'h0;
   localparam logic [3:0] REG_COND   = 4'h9;
   localparam logic [3:0] REG_CNT_LO = 4'hA;
   localparam logic [3:0] REG_CNT_HI = 4'hB;

   localparam logic [4:0] OP_IMM  = 5'd0;
   localparam logic [4:0] OP_MOV  = 5'd1;
   localparam logic [4:0] OP_ADD  = 5'd2;
   localparam logic [4:0] OP_SUB  = 5'd3;
   localparam logic [4:0] OP_MUL  = 5'd4;
   localparam logic [4:0] OP_DIV  = 5'd5;
   localparam logic [4:0] OP_NOT  = 5'd6;
   localparam logic [4:0] OP_AND  = 5'd7;
   localparam logic [4:0] OP_NAND = 5'd8;
   localparam logic [4:0] OP_OR   = 5'd9;
   localparam logic [4:0] OP_NOR  = 5'd10;
   localparam logic [4:0] OP_XOR  = 5'd11;
   localparam logic [4:0] OP_XNOR = 5'd12;
   localparam logic [4:0] OP_SHL  = 5'd13;
   localparam logic [4:0] OP_SHR  = 5'd14;
   localparam logic [4:0] OP_CEQ  = 5'd15;
   localparam logic [4:0] OP_CGT  = 5'd16;
   localparam logic [4:0] OP_CLT  = 5'd17;
   localparam logic [4:0] OP_JMP  = 5'd18;
   localparam logic [4:0] OP_JZ   = 5'd19;
   localparam logic [4:0] OP_JNZ  = 5'd20;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_WRITE,
      CLS_CMP,
      CLS_JUMP
   } cls_type;

   typedef struct packed {
      logic [4:0] operation;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
      logic [3:0] dest;
   } req_type;

   typedef struct packed {
      logic        dest_written;
      logic [3:0]  dest_index;
      logic [7:0]  dest_value;
      logic        condition;
      logic        jump_taken;
      logic [15:0] jump_target;
      logic        div_by_zero;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
      cls_type    cls;
      logic [7:0] a;
      logic [7:0] b;
      logic [3:0] dest;
      logic       a_ok;
      logic       b_ok;
      logic       dest_ok;
   } dec_type;

   // One restoring divide step: returns {remainder, quotient}.
   function automatic logic [15:0] div_step(input logic [7:0] rem, input logic [7:0] quo,
                                            input logic [7:0] divisor);
      logic [8:0] sh;
      logic [7:0] q;
      sh = {rem, quo[7]};
      q  = {quo[6:0], 1'b0};
      if (sh >= {1'b0, divisor}) begin
         sh   = sh - {1'b0, divisor};
         q[0] = 1'b1;
      end
      return {sh[7:0], q};
   endfunction

endpackage

// ----- sv/ebrae_ram.sv -----
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module ebrae_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ----- sv/ebrae_front.sv -----
// Front end: accepts request beats, classifies them and checks register indexes.
// Depends on ebrae_pkg.
`timescale 1ns / 1ps

module ebrae_front #(
   parameter int NUM_REGS = ebrae_pkg::NUM_REGS_DEFAULT
) (
   input  logic               req_valid,
   input  ebrae_pkg::req_type req_payload,
   output logic               req_stall,
   input  logic               q_full,
   output logic               q_push,
   output ebrae_pkg::dec_type q_data
);

   localparam logic [8:0] LIMIT = 9'(NUM_REGS);

   ebrae_pkg::cls_type cls;

   always_comb begin
      case (req_payload.operation) inside
         [ebrae_pkg::OP_IMM:ebrae_pkg::OP_SHR]: cls = ebrae_pkg::CLS_WRITE;
         [ebrae_pkg::OP_CEQ:ebrae_pkg::OP_CLT]: cls = ebrae_pkg::CLS_CMP;
         [ebrae_pkg::OP_JMP:ebrae_pkg::OP_JNZ]: cls = ebrae_pkg::CLS_JUMP;
         default:                               cls = ebrae_pkg::CLS_NONE;
      endcase
   end

   always_comb begin
      q_data.op      = req_payload.operation;
      q_data.cls     = cls;
      q_data.a       = req_payload.operand_a;
      q_data.b       = req_payload.operand_b;
      q_data.dest    = req_payload.dest;
      q_data.a_ok    = (req_payload.operand_a != 8'd0) && ({1'b0, req_payload.operand_a} < LIMIT);
      q_data.b_ok    = (req_payload.operand_b != 8'd0) && ({1'b0, req_payload.operand_b} < LIMIT);
      q_data.dest_ok = (req_payload.dest != ebrae_pkg::REG_ZERO)
                       && ({5'd0, req_payload.dest} < LIMIT);
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// ----- sv/ebrae_queue.sv -----
// Short queue of decoded beats between the front and back ends.
// Depends on ebrae_pkg.
`timescale 1ns / 1ps

module ebrae_queue #(
   parameter int DEPTH = ebrae_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ebrae_pkg::dec_type push_data,
   output logic               full,
   input  logic               pop,
   output ebrae_pkg::dec_type pop_data,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

   ebrae_pkg::dec_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == FULLC);
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/ebrae_back.sv -----
// Back end: register file, operation sequencer, iterative divider, response register.
// Depends on ebrae_pkg and ebrae_ram.
`timescale 1ns / 1ps

module ebrae_back #(
   parameter int NUM_REGS = ebrae_pkg::NUM_REGS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  ebrae_pkg::dec_type q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   output ebrae_pkg::rsp_type rsp_payload,
   input  logic               rsp_stall
);

   localparam int IDX_W = $clog2(NUM_REGS);
   localparam int CNT_W = (ebrae_pkg::DIV_CYCLES > 1) ? $clog2(ebrae_pkg::DIV_CYCLES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ebrae_pkg::DIV_CYCLES - 1);
   localparam logic [IDX_W-1:0] IDX_COND = IDX_W'(ebrae_pkg::REG_COND);
   localparam logic [IDX_W-1:0] IDX_LO   = IDX_W'(ebrae_pkg::REG_CNT_LO);
   localparam logic [IDX_W-1:0] IDX_HI   = IDX_W'(ebrae_pkg::REG_CNT_HI);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } back_state_type;

   back_state_type     state_ff, state_in;
   ebrae_pkg::dec_type cur_ff, cur_in;
   logic [NUM_REGS-1:0] valid_ff, valid_in;
   logic [7:0]         cond_ff, cond_in;
   logic [7:0]         lo_ff, lo_in;
   logic [7:0]         hi_ff, hi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ebrae_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic               wen_ff, wen_in;
   logic [IDX_W-1:0]   widx_ff, widx_in;
   logic [7:0]         wdata_ff, wdata_in;
   logic               jump_ff, jump_in;
   logic               dz_ff, dz_in;
   logic [7:0]         rem_ff, rem_in;
   logic [7:0]         quo_ff, quo_in;
   logic [7:0]         divisor_ff, divisor_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [IDX_W-1:0]   raddr_a, raddr_b;
   logic [7:0]         rdata_a, rdata_b;
   logic [IDX_W-1:0]   ra, rb;
   logic [7:0]         x, y;
   logic [7:0]         prod;
   logic [7:0]         val;
   logic               dz;
   logic               start_div;
   logic               cmp_hit;
   logic               jump;
   logic               fire;
   logic               ram_we;
   logic [7:0]         cond_nx, lo_nx, hi_nx;
   logic [7:0]         div_rem, div_quo;

   assign raddr_a = q_data.a_ok ? q_data.a[IDX_W-1:0] : '0;
   assign raddr_b = q_data.b_ok ? q_data.b[IDX_W-1:0] : '0;

   ebrae_ram #(
      .WIDTH (8),
      .DEPTH (NUM_REGS)
   ) u_regs (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (widx_ff),
      .wdata   (wdata_ff),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   assign ra = cur_ff.a_ok ? cur_ff.a[IDX_W-1:0] : '0;
   assign rb = cur_ff.b_ok ? cur_ff.b[IDX_W-1:0] : '0;

   always_comb begin
      x = 8'd0;
      if (cur_ff.a_ok) begin
         if (ra == IDX_COND) begin
            x = cond_ff;
         end else if (ra == IDX_LO) begin
            x = lo_ff;
         end else if (ra == IDX_HI) begin
            x = hi_ff;
         end else if (valid_ff[ra]) begin
            x = rdata_a;
         end
      end
   end

   always_comb begin
      y = 8'd0;
      if (cur_ff.b_ok) begin
         if (rb == IDX_COND) begin
            y = cond_ff;
         end else if (rb == IDX_LO) begin
            y = lo_ff;
         end else if (rb == IDX_HI) begin
            y = hi_ff;
         end else if (valid_ff[rb]) begin
            y = rdata_b;
         end
      end
   end

   assign prod = x * y;

   always_comb begin
      val       = 8'd0;
      dz        = 1'b0;
      start_div = 1'b0;
      cmp_hit   = 1'b0;
      jump      = 1'b0;
      case (cur_ff.op)
         ebrae_pkg::OP_IMM:  val = cur_ff.a;
         ebrae_pkg::OP_MOV:  val = x;
         ebrae_pkg::OP_ADD:  val = x + y;
         ebrae_pkg::OP_SUB:  val = x - y;
         ebrae_pkg::OP_MUL:  val = prod;
         ebrae_pkg::OP_DIV: begin
            if (y == 8'd0) begin
               val = 8'hFF;
               dz  = 1'b1;
            end else begin
               start_div = 1'b1;
            end
         end
         ebrae_pkg::OP_NOT:  val = ~x;
         ebrae_pkg::OP_AND:  val = x & y;
         ebrae_pkg::OP_NAND: val = ~(x & y);
         ebrae_pkg::OP_OR:   val = x | y;
         ebrae_pkg::OP_NOR:  val = ~(x | y);
         ebrae_pkg::OP_XOR:  val = x ^ y;
         ebrae_pkg::OP_XNOR: val = ~(x ^ y);
         ebrae_pkg::OP_SHL:  val = (y >= 8'd8) ? 8'd0 : (x << y[2:0]);
         ebrae_pkg::OP_SHR:  val = (y >= 8'd8) ? 8'd0 : (x >> y[2:0]);
         ebrae_pkg::OP_CEQ:  cmp_hit = (x == y);
         ebrae_pkg::OP_CGT:  cmp_hit = (x > y);
         ebrae_pkg::OP_CLT:  cmp_hit = (x < y);
         ebrae_pkg::OP_JMP:  jump = 1'b1;
         ebrae_pkg::OP_JZ:   jump = (cond_ff == 8'd0);
         ebrae_pkg::OP_JNZ:  jump = (cond_ff != 8'd0);
         default: begin
         end
      endcase
   end

   always_comb begin
      div_rem = rem_ff;
      div_quo = quo_ff;
      for (int i = 0; i < ebrae_pkg::DIV_BITS_PER_CYCLE; i++) begin
         {div_rem, div_quo} = ebrae_pkg::div_step(div_rem, div_quo, divisor_ff);
      end
   end

   always_comb begin
      cond_nx = cond_ff;
      lo_nx   = lo_ff;
      hi_nx   = hi_ff;
      if (wen_ff) begin
         if (widx_ff == IDX_COND) begin
            cond_nx = wdata_ff;
         end else if (widx_ff == IDX_LO) begin
            lo_nx = wdata_ff;
         end else if (widx_ff == IDX_HI) begin
            hi_nx = wdata_ff;
         end
      end
      if (jump_ff) begin
         lo_nx = cur_ff.a;
         hi_nx = cur_ff.b;
      end
   end

   assign fire   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign ram_we = fire && wen_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      valid_in     = valid_ff;
      cond_in      = cond_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wen_in       = wen_ff;
      widx_in      = widx_ff;
      wdata_in     = wdata_ff;
      jump_in      = jump_ff;
      dz_in        = dz_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      divisor_in   = divisor_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            jump_in  = (cur_ff.cls == ebrae_pkg::CLS_JUMP) && jump;
            dz_in    = dz;
            wdata_in = val;
            case (cur_ff.cls)
               ebrae_pkg::CLS_WRITE: begin
                  wen_in  = cur_ff.dest_ok;
                  widx_in = cur_ff.dest[IDX_W-1:0];
               end
               ebrae_pkg::CLS_CMP: begin
                  wen_in   = 1'b1;
                  widx_in  = IDX_COND;
                  wdata_in = {7'd0, cmp_hit};
               end
               default: begin
                  wen_in  = 1'b0;
                  widx_in = '0;
               end
            endcase
            if (start_div) begin
               rem_in     = 8'd0;
               quo_in     = x;
               divisor_in = y;
               cnt_in     = '0;
               state_in   = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            rem_in = div_rem;
            quo_in = div_quo;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               wdata_in = div_quo;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (fire) begin
               if (wen_ff) begin
                  valid_in[widx_ff] = 1'b1;
               end
               cond_in                  = cond_nx;
               lo_in                    = lo_nx;
               hi_in                    = hi_nx;
               rsp_valid_in             = 1'b1;
               rsp_data_in.dest_written = (cur_ff.cls == ebrae_pkg::CLS_WRITE) && wen_ff;
               rsp_data_in.dest_index   = (cur_ff.cls == ebrae_pkg::CLS_WRITE) ? cur_ff.dest
                                                                               : 4'd0;
               rsp_data_in.dest_value   = (cur_ff.cls == ebrae_pkg::CLS_WRITE) ? wdata_ff
                                                                               : 8'd0;
               rsp_data_in.condition    = (cond_nx != 8'd0);
               rsp_data_in.jump_taken   = jump_ff;
               rsp_data_in.jump_target  = {hi_nx, lo_nx};
               rsp_data_in.div_by_zero  = dz_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         cond_ff      <= 8'd0;
         lo_ff        <= 8'd0;
         hi_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         cond_ff      <= cond_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
      wen_ff      <= wen_in;
      widx_ff     <= widx_in;
      wdata_ff    <= wdata_in;
      jump_ff     <= jump_in;
      dz_ff       <= dz_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      divisor_ff  <= divisor_in;
      cnt_ff      <= cnt_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ----- sv/eight_bit_register_alu_execute_top.sv -----
// Top level of the eight-bit register ALU execute block.
// Depends on ebrae_pkg, ebrae_front, ebrae_queue and ebrae_back.
`timescale 1ns / 1ps

// Executes one decoded instruction per request beat against a register file of
// NUM_REGS 8-bit registers, cleared at reset, and returns one response beat per
// request. The front end classifies each beat into a two-entry queue; the back end
// takes one instruction at a time through execute and done states to the response
// register; a divide by a nonzero divisor also passes a divide state, its quotient
// coming from an iterative divider resolving 2 bits per cycle. The sequencer, with
// one register-file read and one write per instruction, sets the pace. A response
// waiting under stall holds the back end only; requests enter the queue until full.

module eight_bit_register_alu_execute_top #(
   parameter int NUM_REGS = ebrae_pkg::NUM_REGS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  ebrae_pkg::req_type req_payload,
   output logic               req_stall,
   output logic               rsp_valid,
   output ebrae_pkg::rsp_type rsp_payload,
   input  logic               rsp_stall
);

   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   ebrae_pkg::dec_type q_in;
   ebrae_pkg::dec_type q_out;

   ebrae_front #(
      .NUM_REGS (NUM_REGS)
   ) u_front (
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_in)
   );

   ebrae_queue #(
      .DEPTH (ebrae_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   ebrae_back #(
      .NUM_REGS (NUM_REGS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_out),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule

// ----- sv/ebrae_checker.sv -----
// Port-level checker for the eight-bit register ALU execute block, with its bind.
// Depends on ebrae_pkg and eight_bit_register_alu_execute_top.
`timescale 1ns / 1ps

module ebrae_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ebrae_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed under stall");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.dest_written |-> rsp_payload.dest_index != 4'd0)
      else $error("write reported to register zero");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.div_by_zero
         |-> rsp_payload.dest_value == 8'hFF && !rsp_payload.jump_taken)
      else $error("divide by zero beat malformed");

   a_jump_no_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.jump_taken
         |-> !rsp_payload.dest_written && rsp_payload.dest_index == 4'd0
             && rsp_payload.dest_value == 8'd0)
      else $error("jump beat carries destination fields");

endmodule

bind eight_bit_register_alu_execute_top ebrae_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
